[hdl/dwlf_pkg.sv]
// Package for the decaying wave LED folder.
// Holds sizes, fixed-point constants, sequencer states, control struct and tap addressing.
// No dependencies.
package dwlf_pkg;

  localparam int PIXELS   = 30;
  localparam int ROWS     = 5;
  localparam int WAVE_LEN = ROWS * PIXELS;

  localparam int ADDR_W  = (WAVE_LEN > 1) ? $clog2(WAVE_LEN) : 1;
  localparam int PIX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LEVEL_W = 16;
  localparam int ACC_W   = LEVEL_W + ((ROWS > 1) ? $clog2(ROWS) : 0);
  localparam int DECAY_W = 16;
  localparam int DIST_W  = 12;
  localparam int IDX_W   = 5;
  localparam int COLOR_W = 8;
  localparam int MUL_W   = LEVEL_W + DECAY_W;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd64815;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 16'd65280;
  // 255 * 5: from here on the head level is zero
  localparam logic [DIST_W-1:0]  FAR_MM      = 12'd1275;
  // floor(mm * 256 / 5) = 51 * mm + floor(mm / 5); mm / 5 = (mm * 52429) >> 18
  localparam int                 DIV5_INT     = 51;
  localparam logic [DECAY_W-1:0] RECIP5       = 16'd52429;
  localparam int                 RECIP5_SHIFT = 18;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHIFT,
    ST_DRAIN,
    ST_HEAD_MUL,
    ST_HEAD_WR,
    ST_SUM,
    ST_SUM_WAIT,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    WSEL_ZERO,
    WSEL_DECAY,
    WSEL_HEAD
  } wsel_e;

  typedef struct packed {
    logic              mm_load;
    logic              mul_head;
    logic              acc_clr;
    logic              acc_add;
    logic              we;
    wsel_e             wsel;
    logic [ADDR_W-1:0] waddr;
    logic              out_load;
  } ctrl_t;

  // serpentine tap: even rows run forward, odd rows backward
  function automatic logic [ADDR_W-1:0] tap_addr(input logic [ROW_W-1:0] row,
                                                 input logic [PIX_W-1:0] pix);
    logic [ADDR_W:0] res;
    if (row[0]) begin
      res = (ADDR_W+1)'((int'(row) + 1) * PIXELS - 1 - int'(pix));
    end else begin
      res = (ADDR_W+1)'(int'(row) * PIXELS + int'(pix));
    end
    return res[ADDR_W-1:0];
  endfunction

endpackage

[hdl/dwlf_in_if.sv]
// Sample request channel: valid/ready plus distance payload.
// Depends on dwlf_pkg.
interface dwlf_in_if import dwlf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_mm;

  modport source (output valid, output distance_mm, input ready);
  modport sink   (input valid, input distance_mm, output ready);
endinterface

[hdl/dwlf_out_if.sv]
// Pixel result channel: valid/ready plus pixel index, colors and last flag.
// Depends on dwlf_pkg.
interface dwlf_out_if import dwlf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   pixel_index;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] blue;
  logic               last;

  modport source (output valid, output pixel_index, output red, output blue, output last,
                  input ready);
  modport sink   (input valid, input pixel_index, input red, input blue, input last,
                  output ready);
endinterface

[hdl/dwlf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dwlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 150,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/dwlf_seq.sv]
// Sequencer: clear sweep, shift-and-decay pass, head write, per-pixel tap sums, emit.
// Depends on dwlf_pkg.
module dwlf_seq import dwlf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [IDX_W-1:0]  pixel_index_o,
  output logic              last_o,
  output logic [ADDR_W-1:0] raddr_o,
  output ctrl_t             ctrl_o
);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [PIX_W-1:0]  pix_q, pix_d;
  logic              p1_vld_q, p2_vld_q;
  logic [ADDR_W-1:0] p1_addr_q, p2_addr_q;
  logic              rv_q;
  logic              out_vld_q, out_vld_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              last_q, last_d;
  logic              slot_free;
  logic              accept;
  logic              row_end, pix_end, clr_end;

  assign slot_free = !out_vld_q || out_ready_i;
  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign row_end   = (row_q == ROW_W'(ROWS - 1));
  assign pix_end   = (pix_q == PIX_W'(PIXELS - 1));
  assign clr_end   = (cnt_q == ADDR_W'(WAVE_LEN - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_end) state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_SHIFT;
      ST_SHIFT:    if (cnt_q == '0) state_d = ST_DRAIN;
      ST_DRAIN:    if (!p1_vld_q && !p2_vld_q) state_d = ST_HEAD_MUL;
      ST_HEAD_MUL: state_d = ST_HEAD_WR;
      ST_HEAD_WR:  state_d = ST_SUM;
      ST_SUM:      if (row_end) state_d = ST_SUM_WAIT;
      ST_SUM_WAIT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_d = pix_end ? ST_IDLE : ST_SUM;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.wsel     = WSEL_ZERO;
    ctrl_o.mm_load  = accept;
    ctrl_o.mul_head = (state_q == ST_HEAD_MUL);
    ctrl_o.acc_add  = rv_q;
    ctrl_o.out_load = (state_q == ST_EMIT) && slot_free;
    ctrl_o.acc_clr  = (state_q == ST_HEAD_WR) || ctrl_o.out_load;
    if (state_q == ST_CLEAR) begin
      ctrl_o.we    = 1'b1;
      ctrl_o.wsel  = WSEL_ZERO;
      ctrl_o.waddr = cnt_q;
    end else if (state_q == ST_HEAD_WR) begin
      ctrl_o.we    = 1'b1;
      ctrl_o.wsel  = WSEL_HEAD;
      ctrl_o.waddr = '0;
    end else if (p2_vld_q) begin
      ctrl_o.we    = 1'b1;
      ctrl_o.wsel  = WSEL_DECAY;
      ctrl_o.waddr = p2_addr_q;
    end
    raddr_o = (state_q == ST_SHIFT) ? cnt_q : tap_addr(row_q, pix_q);
  end

  always_comb begin
    cnt_d     = cnt_q;
    row_d     = row_q;
    pix_d     = pix_q;
    out_vld_d = out_vld_q && !out_ready_i;
    idx_d     = idx_q;
    last_d    = last_q;
    case (state_q)
      ST_CLEAR:   cnt_d = cnt_q + 1'b1;
      ST_IDLE:    if (in_valid_i) cnt_d = ADDR_W'(WAVE_LEN - 2);
      ST_SHIFT:   cnt_d = cnt_q - 1'b1;
      ST_HEAD_WR: begin
        pix_d = '0;
        row_d = '0;
      end
      ST_SUM:     row_d = row_end ? '0 : row_q + 1'b1;
      ST_EMIT: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          idx_d     = IDX_W'(pix_q);
          last_d    = pix_end;
          pix_d     = pix_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      row_q     <= '0;
      pix_q     <= '0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p1_addr_q <= '0;
      p2_addr_q <= '0;
      rv_q      <= 1'b0;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      row_q     <= row_d;
      pix_q     <= pix_d;
      p1_vld_q  <= (state_q == ST_SHIFT);
      p1_addr_q <= cnt_q + 1'b1;
      p2_vld_q  <= p1_vld_q;
      p2_addr_q <= p1_addr_q;
      rv_q      <= (state_q == ST_SUM);
      out_vld_q <= out_vld_d;
      idx_q     <= idx_d;
      last_q    <= last_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_vld_q;
  assign pixel_index_o = idx_q;
  assign last_o        = last_q;

endmodule

[hdl/dwlf_dp.sv]
// Datapath: decay register, shared multiplier, head level, tap accumulator, color output.
// Depends on dwlf_pkg.
module dwlf_dp import dwlf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  logic               decay_we_i,
  input  logic [DECAY_W-1:0] decay_factor_i,
  input  logic [DIST_W-1:0]  distance_mm_i,
  input  logic [LEVEL_W-1:0] rdata_i,
  output logic [LEVEL_W-1:0] wdata_o,
  output logic [COLOR_W-1:0] red_o,
  output logic [COLOR_W-1:0] blue_o
);

  logic [DECAY_W-1:0] decay_q;
  logic [DIST_W-1:0]  mm_q;
  logic [MUL_W-1:0]   mul_q;
  logic [LEVEL_W-1:0] mul_a;
  logic [DECAY_W-1:0] mul_b;
  logic [MUL_W-1:0]   quot5;
  logic [LEVEL_W:0]   head_q8;
  logic [LEVEL_W-1:0] head_lvl;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [LEVEL_W-1:0] sum_c, rest;
  logic [COLOR_W-1:0] red_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RESET;
    end else if (decay_we_i) begin
      decay_q <= decay_factor_i;
    end
  end

  // one multiplier: decay products during the shift pass, reciprocal of 5 for the head
  assign mul_a = ctrl_i.mul_head ? LEVEL_W'(mm_q) : rdata_i;
  assign mul_b = ctrl_i.mul_head ? RECIP5 : decay_q;

  assign quot5    = mul_q >> RECIP5_SHIFT;
  assign head_q8  = (LEVEL_W+1)'(int'(mm_q) * DIV5_INT) + (LEVEL_W+1)'(quot5);
  assign head_lvl = (mm_q >= FAR_MM) ? '0 : FULL_LEVEL - head_q8[LEVEL_W-1:0];

  always_comb begin
    case (ctrl_i.wsel)
      WSEL_DECAY: wdata_o = mul_q[MUL_W-1 -: LEVEL_W];
      WSEL_HEAD:  wdata_o = head_lvl;
      default:    wdata_o = '0;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_add) begin
      acc_d = acc_q + ACC_W'(rdata_i);
    end
  end

  assign sum_c = (acc_q > ACC_W'(FULL_LEVEL)) ? FULL_LEVEL : acc_q[LEVEL_W-1:0];
  assign rest  = FULL_LEVEL - sum_c;

  always_ff @(posedge clk_i) begin
    mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
    acc_q <= acc_d;
    if (ctrl_i.mm_load) begin
      mm_q <= distance_mm_i;
    end
    if (ctrl_i.out_load) begin
      red_q  <= sum_c[LEVEL_W-1 -: COLOR_W];
      blue_q <= rest[LEVEL_W-1 -: COLOR_W];
    end
  end

  assign red_o  = red_q;
  assign blue_o = blue_q;

endmodule

[hdl/decaying_wave_led_folder.sv]
// Each request runs a shift-and-decay pass over the wave store, a head write and the per-pixel
// tap sums; the single RAM read port, visited once per moved level and once per tap, sets
// the pace. A new request is taken only after the last pixel of the previous one is loaded.
// Results leave one per pixel.
// Reset: async active low; a clearing sweep over all WAVE_LEN (150) addresses zeroes the wave store,
// with no request taken meanwhile. Decay register resets to 64815.
// Depends on dwlf_pkg, dwlf_in_if, dwlf_out_if, dwlf_ram, dwlf_seq, dwlf_dp.
module decaying_wave_led_folder import dwlf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  dwlf_in_if.sink            sample_i,
  dwlf_out_if.source         pixel_o,
  input  logic               decay_we_i,
  input  logic [DECAY_W-1:0] decay_factor_i
);

  ctrl_t              ctrl;
  logic [ADDR_W-1:0]  raddr;
  logic [LEVEL_W-1:0] rdata;
  logic [LEVEL_W-1:0] wdata;

  dwlf_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (sample_i.valid),
    .in_ready_o    (sample_i.ready),
    .out_ready_i   (pixel_o.ready),
    .out_valid_o   (pixel_o.valid),
    .pixel_index_o (pixel_o.pixel_index),
    .last_o        (pixel_o.last),
    .raddr_o       (raddr),
    .ctrl_o        (ctrl)
  );

  dwlf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .decay_we_i     (decay_we_i),
    .decay_factor_i (decay_factor_i),
    .distance_mm_i  (sample_i.distance_mm),
    .rdata_i        (rdata),
    .wdata_o        (wdata),
    .red_o          (pixel_o.red),
    .blue_o         (pixel_o.blue)
  );

  dwlf_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (WAVE_LEN),
    .AW    (ADDR_W)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.we),
    .waddr_i (ctrl.waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

[verif/tb_decaying_wave_led_folder.sv]
`timescale 1ns / 100ps
// Self-checking testbench for decaying_wave_led_folder: random-gap driver and stalling monitor.
// Predicts every pixel from its own copy of the wave line and decay register.
// Depends on dwlf_pkg, dwlf_in_if, dwlf_out_if and the block's RTL.
module tb_decaying_wave_led_folder;
  import dwlf_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 1_500_000;
  localparam int unsigned LONG_HOLD       = 1500;
  localparam int unsigned SETTLE_CYCLES   = 400;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  logic               decay_we  = 1'b0;
  logic [DECAY_W-1:0] decay_val = DECAY_RESET;

  dwlf_in_if  sample_if ();
  dwlf_out_if pixel_if ();

  decaying_wave_led_folder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_if),
    .pixel_o        (pixel_if),
    .decay_we_i     (decay_we),
    .decay_factor_i (decay_val)
  );

  always #1 clk_i = ~clk_i;

  logic [LEVEL_W-1:0] wave_lvl [WAVE_LEN];
  logic [DECAY_W-1:0] fade_q16 = DECAY_RESET;
  logic [DIST_W-1:0]  queued_mm [$];
  pixel_t             due_pixels [$];

  bit          quiet_tail      = 1'b0;
  bit          long_hold_armed = 1'b0;
  bit          long_hold_done  = 1'b0;
  int unsigned fault_cnt       = 0;
  int unsigned send_gap        = 0;
  int unsigned stall_left      = 0;
  int unsigned hold_left       = 0;
  int unsigned cycle_cnt       = 0;

  // shift the line with decay, insert the new head, fold the rows into pixels
  function automatic void advance_wave(input logic [DIST_W-1:0] mm);
    logic [31:0] prod;
    logic [31:0] quo;
    logic [31:0] sum;
    int          tap;
    pixel_t      px;
    for (int i = WAVE_LEN - 1; i > 0; i--) begin
      prod        = 32'(wave_lvl[i-1]) * 32'(fade_q16);
      wave_lvl[i] = prod[31:16];
    end
    quo = (32'(mm) * 32'd256) / 32'd5;
    if (quo > 32'(FULL_LEVEL)) quo = 32'(FULL_LEVEL);
    wave_lvl[0] = LEVEL_W'(32'(FULL_LEVEL) - quo);
    for (int pix = 0; pix < PIXELS; pix++) begin
      sum = 0;
      for (int row = 0; row < ROWS; row++) begin
        tap = (row % 2 == 1) ? (row + 1) * PIXELS - 1 - pix : row * PIXELS + pix;
        sum += 32'(wave_lvl[tap]);
      end
      if (sum > 32'(FULL_LEVEL)) sum = 32'(FULL_LEVEL);
      px.pixel_index = IDX_W'(pix);
      px.red         = sum[15:8];
      px.blue        = 8'((32'(FULL_LEVEL) - sum) >> 8);
      px.last        = (pix == PIXELS - 1);
      due_pixels.push_back(px);
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit offer;
    if (!rst_ni) begin
      sample_if.valid       <= 1'b0;
      sample_if.distance_mm <= '0;
      send_gap = 0;
      for (int i = 0; i < WAVE_LEN; i++) wave_lvl[i] = '0;
    end else begin
      offer = 1'b0;
      if (sample_if.valid && sample_if.ready) begin
        advance_wave(sample_if.distance_mm);
        void'(queued_mm.pop_front());
        if (!quiet_tail && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 16);
      end else if (sample_if.valid) begin
        offer = 1'b1;
      end
      if (!offer) begin
        if (send_gap > 0) send_gap--;
        else if (queued_mm.size() > 0) offer = 1'b1;
      end
      sample_if.valid <= offer;
      if (offer) sample_if.distance_mm <= queued_mm[0];
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t want;
    bit     rdy;
    if (!rst_ni) begin
      pixel_if.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (pixel_if.valid && pixel_if.ready) begin
        got.pixel_index = pixel_if.pixel_index;
        got.red         = pixel_if.red;
        got.blue        = pixel_if.blue;
        got.last        = pixel_if.last;
        if (due_pixels.size() == 0) begin
          $error("unexpected pixel result: pixel_index %0d red %0d blue %0d last %0d",
                 got.pixel_index, got.red, got.blue, got.last);
          fault_cnt++;
        end else begin
          want = due_pixels.pop_front();
          if (got.pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, actual %0d", want.pixel_index, got.pixel_index);
            fault_cnt++;
          end
          if (got.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, got.red);
            fault_cnt++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, got.blue);
            fault_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fault_cnt++;
          end
        end
        if (long_hold_armed && !long_hold_done) begin
          hold_left      = LONG_HOLD;
          long_hold_done = 1'b1;
        end
      end
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rdy        = 1'b0;
      end
      pixel_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= WATCHDOG_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic load_decay(input logic [DECAY_W-1:0] v);
    @(posedge clk_i);
    decay_we  <= 1'b1;
    decay_val <= v;
    fade_q16 = v;
    @(posedge clk_i);
    decay_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (queued_mm.size() != 0 || due_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // runs of nearby distances that drift, with some full-range noise mixed in
  task automatic queue_swells(input int n, input int top_mm);
    int run_left;
    int center;
    int v;
    run_left = 0;
    center   = 0;
    for (int k = 0; k < n; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 30);
        center   = $urandom_range(0, top_mm);
      end
      run_left--;
      if ($urandom_range(0, 7) == 0) begin
        v = $urandom_range(0, 4095);
      end else begin
        center = center + int'($urandom_range(0, 10)) - 5;
        if (center < 0) center = 0;
        v = center + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      queued_mm.push_back(DIST_W'(v));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, far threshold, divide rounding, alternating bits
    queued_mm = {12'd0, 12'd4095, 12'd1274, 12'd1275, 12'd1276, 12'd1, 12'd4, 12'd5, 12'd6,
                 12'd2048, 12'h555, 12'hAAA, 12'd4094, 12'd1023, 12'd255, 12'd0, 12'd0,
                 12'd0, 12'd640, 12'd1280};
    wait_drained();

    // no decay with close objects drives the folded sum into saturation
    load_decay(16'hFFFF);
    queue_swells(70, 60);
    wait_drained();

    load_decay(16'h0000);
    queue_swells(30, 4095);
    wait_drained();

    load_decay(DECAY_W'($urandom_range(1, 65534)));
    long_hold_armed = 1'b1;
    queue_swells(80, 1300);
    wait_drained();

    load_decay(16'h8000);
    queue_swells(50, 1300);
    wait_drained();

    quiet_tail = 1'b1;
    load_decay(DECAY_RESET);
    queue_swells(60, 1300);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0 && due_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/dwlf_pkg.sv
hdl/dwlf_in_if.sv
hdl/dwlf_out_if.sv
hdl/dwlf_ram.sv
hdl/dwlf_seq.sv
hdl/dwlf_dp.sv
hdl/decaying_wave_led_folder.sv
verif/tb_decaying_wave_led_folder.sv
